FILE: rtl/core/upp_pkg.sv
// Shared types, constants and helpers for the UVC payload packetizer.
// Used by the channel interfaces, the packet step logic and the top level.
package upp_pkg;

	localparam int FRAME_BYTES_BITS = 24;
	localparam int POS_W = (FRAME_BYTES_BITS > 24) ? 24 : FRAME_BYTES_BITS;
	localparam int RAW_W = 25;
	localparam logic [RAW_W-1:0] SIZE_LIMIT = RAW_W'((64'd1 << POS_W) - 64'd1);

	localparam int REQ_W = 12;
	localparam int DIM_W = 12;
	localparam int ALT_W = 8;
	localparam int SIZE_W = 24;
	localparam int OFF_W = 24;
	localparam int CNT_W = 32;
	localparam int HDR_W = 2;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 12;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_SET_ALT = 1'b1;
	localparam logic [ALT_W-1:0] ALT_STOP = 8'd0;
	localparam logic [ALT_W-1:0] ALT_START = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;
	localparam logic [DIM_W-1:0] WIDTH_RESET = 12'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;
	localparam logic [REQ_W-1:0] HDR_LEN = 12'd2;

	typedef struct packed {
		logic opcode;
		logic [REQ_W-1:0] request_len;
		logic [ALT_W-1:0] alt_setting;
		logic [SIZE_W-1:0] frame_size;
		logic frame_size_valid;
		logic burst_last;
	} upp_item_t;

	typedef struct packed {
		logic [REQ_W-1:0] payload_len;
		logic [HDR_W-1:0] header_info;
		logic [OFF_W-1:0] data_offset;
		logic [REQ_W-1:0] data_len;
		logic [CNT_W-1:0] frame_number;
		logic frame_start;
		logic burst_last_out;
	} upp_result_t;

	typedef struct packed {
		logic on;
		logic [POS_W-1:0] cur_len;
		logic [POS_W-1:0] cur_pos;
		logic fid;
		logic [CNT_W-1:0] frame_count;
	} upp_state_t;

	function automatic logic [POS_W-1:0] sat_len(input logic [RAW_W-1:0] n);
		logic [RAW_W-1:0] m;
		m = (n > SIZE_LIMIT) ? SIZE_LIMIT : n;
		return m[POS_W-1:0];
	endfunction

endpackage

FILE: rtl/core/upp_in_if.sv
// Input word channel of the UVC payload packetizer.
// Depends on upp_pkg for field widths.
interface upp_in_if;
	import upp_pkg::*;

	logic valid;
	logic ready;
	logic opcode;
	logic [REQ_W-1:0] request_len;
	logic [ALT_W-1:0] alt_setting;
	logic [SIZE_W-1:0] frame_size;
	logic frame_size_valid;
	logic burst_last;

	modport source (output valid, opcode, request_len, alt_setting, frame_size,
		frame_size_valid, burst_last, input ready);
	modport sink (input valid, opcode, request_len, alt_setting, frame_size,
		frame_size_valid, burst_last, output ready);
endinterface

FILE: rtl/core/upp_out_if.sv
// Result word channel of the UVC payload packetizer.
// Depends on upp_pkg for field widths.
interface upp_out_if;
	import upp_pkg::*;

	logic valid;
	logic ready;
	logic [REQ_W-1:0] payload_len;
	logic [HDR_W-1:0] header_info;
	logic [OFF_W-1:0] data_offset;
	logic [REQ_W-1:0] data_len;
	logic [CNT_W-1:0] frame_number;
	logic frame_start;
	logic burst_last_out;

	modport source (output valid, payload_len, header_info, data_offset, data_len,
		frame_number, frame_start, burst_last_out, input ready);
	modport sink (input valid, payload_len, header_info, data_offset, data_len,
		frame_number, frame_start, burst_last_out, output ready);
endinterface

FILE: rtl/core/upp_cfg_if.sv
// Register write channel of the UVC payload packetizer.
// Depends on upp_pkg for index and data widths.
interface upp_cfg_if;
	import upp_pkg::*;

	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/uvc_payload_packetizer.sv
// Top level of the UVC payload packetizer: input register, step logic, result register.
// Depends on upp_pkg, upp_in_if, upp_out_if, upp_cfg_if and upp_step.
//
// Usage:
//   pkt_in  carries words: a packet request (opcode 0) or a set-alternate (opcode 1).
//   pkt_out carries one result word for every packet request; set-alternate words
//           change the stream state and give no result.
//   cfg     writes frame_width (index 0) and frame_height (index 1); other indexes
//           are ignored. It is always ready.
// A taken word sits in the input register; its result leaves via the result register.
// Throughput: one word per cycle; the input register and the result register
//   each advance every cycle while pkt_out is ready, the frame state loop being
//   subtracts, compares and adds.
// Reset: streaming off, no frame in progress, FID and frame count zero, width 640,
//   height 480; both channels empty.
// Stall: while pkt_out is held off, one result waits in the result register and one
//   packet request waits in the input register; pkt_in then drops ready until pkt_out moves.
module uvc_payload_packetizer (
	input logic clk,
	input logic arst_n,
	upp_in_if.sink pkt_in,
	upp_out_if.source pkt_out,
	upp_cfg_if.sink cfg
);
	import upp_pkg::*;

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] width_d;
	logic [DIM_W-1:0] height_d;
	logic [POS_W-1:0] synth_len_q;
	logic [2*DIM_W-1:0] synth_prod;
	logic [RAW_W-1:0] synth_raw;
	logic cfg_wr;

	upp_item_t item_s1;
	logic valid_s1;
	logic advance;
	logic in_acc;

	upp_state_t state_q;
	upp_state_t state_next;
	upp_result_t result;
	upp_result_t result_q;
	logic out_valid_q;

	assign cfg.ready = 1'b1;
	assign cfg_wr = cfg.valid && cfg.ready;
	assign width_d = (cfg_wr && cfg.index == CFG_FRAME_WIDTH) ? cfg.data : width_q;
	assign height_d = (cfg_wr && cfg.index == CFG_FRAME_HEIGHT) ? cfg.data : height_q;
	assign synth_prod = (2*DIM_W)'(width_d) * (2*DIM_W)'(height_d);
	assign synth_raw = {synth_prod, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			synth_len_q <= sat_len({(2*DIM_W)'(WIDTH_RESET) * (2*DIM_W)'(HEIGHT_RESET), 1'b0});
		end else begin
			width_q <= width_d;
			height_q <= height_d;
			synth_len_q <= sat_len(synth_raw);
		end
	end

	assign advance = valid_s1 && (item_s1.opcode == OP_SET_ALT || !out_valid_q || pkt_out.ready);
	assign pkt_in.ready = !valid_s1 || advance;
	assign in_acc = pkt_in.valid && pkt_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.opcode <= pkt_in.opcode;
			item_s1.request_len <= pkt_in.request_len;
			item_s1.alt_setting <= pkt_in.alt_setting;
			item_s1.frame_size <= pkt_in.frame_size;
			item_s1.frame_size_valid <= pkt_in.frame_size_valid;
			item_s1.burst_last <= pkt_in.burst_last;
		end
	end

	upp_step u_step (
		.item(item_s1),
		.state(state_q),
		.synth_len(synth_len_q),
		.state_next(state_next),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_next;
			end
			if (advance && item_s1.opcode == OP_PACKET) begin
				out_valid_q <= 1'b1;
			end else if (pkt_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.opcode == OP_PACKET) begin
			result_q <= result;
		end
	end

	assign pkt_out.valid = out_valid_q;
	assign pkt_out.payload_len = result_q.payload_len;
	assign pkt_out.header_info = result_q.header_info;
	assign pkt_out.data_offset = result_q.data_offset;
	assign pkt_out.data_len = result_q.data_len;
	assign pkt_out.frame_number = result_q.frame_number;
	assign pkt_out.frame_start = result_q.frame_start;
	assign pkt_out.burst_last_out = result_q.burst_last_out;
endmodule

FILE: rtl/core/upp_step.sv
// Per-word packetizing logic: next stream state and the result word.
// Purely combinational; depends on upp_pkg types and sat_len.
module upp_step (
	input upp_pkg::upp_item_t item,
	input upp_pkg::upp_state_t state,
	input logic [upp_pkg::POS_W-1:0] synth_len,
	output upp_pkg::upp_state_t state_next,
	output upp_pkg::upp_result_t result
);
	import upp_pkg::*;

	logic send;
	logic need_frame;
	logic [POS_W-1:0] len;
	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] src_len;
	logic [REQ_W-1:0] cap;
	logic [POS_W-1:0] cap_ext;
	logic [POS_W-1:0] remain;
	logic [POS_W-1:0] chunk;
	logic [POS_W:0] pos_sum;
	logic frame_done;
	logic eof;

	assign send = state.on && (item.request_len >= HDR_LEN);
	assign need_frame = (state.cur_len == '0);
	assign src_len = sat_len({1'b0, item.frame_size});
	assign len = need_frame ? (item.frame_size_valid ? src_len : synth_len) : state.cur_len;
	assign pos = need_frame ? '0 : state.cur_pos;
	assign cap = item.request_len - HDR_LEN;
	assign cap_ext = POS_W'(cap);
	assign remain = (pos <= len) ? (len - pos) : '0;
	assign chunk = (remain < cap_ext) ? remain : cap_ext;
	assign eof = (chunk >= remain);
	assign pos_sum = {1'b0, pos} + {1'b0, chunk};
	assign frame_done = (pos_sum >= {1'b0, len});

	always_comb begin
		state_next = state;
		result = '0;
		result.burst_last_out = item.burst_last;
		if (item.opcode == OP_SET_ALT) begin
			if (item.alt_setting == ALT_START && !state.on) begin
				state_next.on = 1'b1;
				state_next.cur_len = '0;
				state_next.cur_pos = '0;
				state_next.fid = 1'b0;
				state_next.frame_count = '0;
			end else if (item.alt_setting == ALT_STOP && state.on) begin
				state_next.on = 1'b0;
			end
		end else if (send) begin
			result.payload_len = HDR_LEN + chunk[REQ_W-1:0];
			result.header_info = {eof, state.fid};
			result.data_offset = OFF_W'(pos);
			result.data_len = chunk[REQ_W-1:0];
			result.frame_number = state.frame_count;
			result.frame_start = need_frame;
			if (frame_done) begin
				state_next.cur_len = '0;
				state_next.cur_pos = '0;
				state_next.fid = ~state.fid;
				state_next.frame_count = state.frame_count + 1'b1;
			end else begin
				state_next.cur_len = len;
				state_next.cur_pos = pos_sum[POS_W-1:0];
			end
		end
	end
endmodule
